FILE: hdl/srcr_pkg.sv
// ----------------------------------------------------------------------------
// srcr_pkg
// Shared types and constants for the shift register chain reader: request
// structs for both channels, command codes, register indexes, pin drive group.
// ----------------------------------------------------------------------------
package srcr_pkg;

    // field widths fixed by the interface
    localparam int CMD_W         = 2;
    localparam int PIN_W         = 9;
    localparam int CHIP_COUNT_W  = 6;
    localparam int PULSE_TICKS_W = 8;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_IDX_W     = 1;

    // eight-bit chips per section word
    localparam int CHIPS_PER_SECTION = 4;

    // reset values of the configuration registers
    localparam logic [CHIP_COUNT_W-1:0]  CHIP_COUNT_RST  = 6'd4;
    localparam logic [PULSE_TICKS_W-1:0] PULSE_TICKS_RST = 8'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHIP_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 1'd1;

    // command codes (code 3 behaves as a plain tick)
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [PIN_W-1:0] pin_number;
        logic             serial_in;
    } t_in_req;

    typedef struct packed {
        logic load_n;
        logic shift_clock;
        logic clock_enable;
        logic busy_res;
        logic scan_done;
        logic read_valid;
        logic read_bit;
    } t_out_req;

    // pin drive levels and scan status from the sequencer
    typedef struct packed {
        logic load_n;
        logic shift_clock;
        logic clock_enable;
        logic busy_res;
        logic scan_done;
    } t_drive;

endpackage

FILE: hdl/shift_register_chain_reader.sv
// ----------------------------------------------------------------------------
// shift_register_chain_reader
// Tick-driven reader for a daisy chain of eight-bit parallel-in serial-out
// shift registers, with a cached pin image and single-pin reads.
// ----------------------------------------------------------------------------
// Result: the output register captures the result at the request accept edge.
// Throughput: one request per cycle while o_in_stall is low; the sequencer and
//   cache decode are combinational and feed the result register.
// Reset (synchronous, active low): scan idle, pin cache cleared, chip_count 4,
//   pulse_ticks 5, output register empty.
module shift_register_chain_reader #(
    parameter int MAX_SECTIONS = 8,
    parameter int SECTION_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [srcr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [srcr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  srcr_pkg::t_in_req                 i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output srcr_pkg::t_out_req                o_out_req
);
    import srcr_pkg::*;

    localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int SCNT_W = $clog2(MAX_SECTIONS+1);

    logic [CHIP_COUNT_W-1:0]  r_chip_count;
    logic [PULSE_TICKS_W-1:0] r_pulse_ticks;
    logic                     r_out_valid;
    t_out_req                 r_out_req, n_out_req;
    logic                     w_accept;
    logic [CHIP_COUNT_W-1:0]  w_chips;
    logic [CHIP_COUNT_W:0]    w_sec_raw;
    logic [SCNT_W-1:0]        w_sections;
    t_drive                   w_drive;
    logic                     w_store_en;
    logic [SEC_W-1:0]         w_store_sec;
    logic [SECTION_BITS-1:0]  w_store_data;
    logic                     w_read_valid;
    logic                     w_read_bit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_count  <= CHIP_COUNT_RST;
            r_pulse_ticks <= PULSE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_CHIP_COUNT:  r_chip_count  <= i_cfg_data[CHIP_COUNT_W-1:0];
                REG_PULSE_TICKS: r_pulse_ticks <= i_cfg_data[PULSE_TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // section count: ceil(chips / 4), at least one, capped at MAX_SECTIONS
    assign w_chips   = (r_chip_count == '0) ? CHIP_COUNT_W'(1) : r_chip_count;
    assign w_sec_raw = ({1'b0, w_chips} + (CHIP_COUNT_W+1)'(CHIPS_PER_SECTION - 1))
                       / (CHIP_COUNT_W+1)'(CHIPS_PER_SECTION);
    assign w_sections = (w_sec_raw > (CHIP_COUNT_W+1)'(MAX_SECTIONS))
                        ? SCNT_W'(MAX_SECTIONS) : SCNT_W'(w_sec_raw);

    // handshake: take a request whenever the result register is free or drains
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    srcr_seq #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SECTION_BITS (SECTION_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_accept),
        .i_command     (i_in_req.command),
        .i_serial_in   (i_in_req.serial_in),
        .i_sections    (w_sections),
        .i_pulse_ticks (r_pulse_ticks),
        .o_drive       (w_drive),
        .o_store_en    (w_store_en),
        .o_store_sec   (w_store_sec),
        .o_store_data  (w_store_data)
    );

    srcr_cache #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .SECTION_BITS (SECTION_BITS)
    ) u_cache (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_store_en   (w_store_en),
        .i_store_sec  (w_store_sec),
        .i_store_data (w_store_data),
        .i_read_req   (i_in_req.command == CMD_READ),
        .i_pin        (i_in_req.pin_number),
        .i_sections   (w_sections),
        .o_read_valid (w_read_valid),
        .o_read_bit   (w_read_bit)
    );

    // result assembly
    always_comb begin
        n_out_req.load_n       = w_drive.load_n;
        n_out_req.shift_clock  = w_drive.shift_clock;
        n_out_req.clock_enable = w_drive.clock_enable;
        n_out_req.busy_res     = w_drive.busy_res;
        n_out_req.scan_done    = w_drive.scan_done;
        n_out_req.read_valid   = w_read_valid;
        n_out_req.read_bit     = w_read_bit;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_req <= n_out_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

FILE: hdl/srcr_seq.sv
// ----------------------------------------------------------------------------
// srcr_seq
// Scan sequencer: load pulse, then per bit one sample tick with the clock low
// and pulse_ticks ticks with the clock high; assembles section words.
// ----------------------------------------------------------------------------
module srcr_seq #(
    parameter int MAX_SECTIONS = 8,
    parameter int SECTION_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [srcr_pkg::CMD_W-1:0]          i_command,
    input  logic                                i_serial_in,
    input  logic [$clog2(MAX_SECTIONS+1)-1:0]   i_sections,
    input  logic [srcr_pkg::PULSE_TICKS_W-1:0]  i_pulse_ticks,
    output srcr_pkg::t_drive                    o_drive,
    output logic                                o_store_en,
    output logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] o_store_sec,
    output logic [SECTION_BITS-1:0]             o_store_data
);
    import srcr_pkg::*;

    localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int POS_W  = $clog2(SECTION_BITS);
    localparam int SCNT_W = $clog2(MAX_SECTIONS+1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOAD,
        PH_SAMPLE,
        PH_CLKHI
    } t_phase;

    t_phase                   r_phase, n_phase, w_phase;
    logic [PULSE_TICKS_W-1:0] r_tick, n_tick, w_tick;
    logic [POS_W-1:0]         r_bit, n_bit, w_bit;
    logic [SEC_W-1:0]         r_sec, n_sec, w_sec;
    logic [SECTION_BITS-1:0]  r_acc, n_acc, w_acc;
    logic [PULSE_TICKS_W-1:0] w_pulse;
    logic [PULSE_TICKS_W:0]   w_tick_inc;
    logic                     w_pulse_end;
    t_drive                   w_drive;
    logic                     w_store;

    // zero pulse width counts as one tick
    assign w_pulse    = (i_pulse_ticks == '0) ? PULSE_TICKS_W'(1) : i_pulse_ticks;
    assign w_tick_inc = {1'b0, w_tick} + (PULSE_TICKS_W+1)'(1);
    assign w_pulse_end = (w_tick_inc >= {1'b0, w_pulse});

    // start is taken before the phase work of the same tick
    always_comb begin
        if (i_command == CMD_START && r_phase == PH_IDLE) begin
            w_phase = PH_LOAD;
            w_tick  = '0;
            w_bit   = '0;
            w_acc   = '0;
            w_sec   = SEC_W'(i_sections - SCNT_W'(1));
        end else begin
            w_phase = r_phase;
            w_tick  = r_tick;
            w_bit   = r_bit;
            w_acc   = r_acc;
            w_sec   = r_sec;
        end
    end

    // phase work and drive levels
    always_comb begin
        n_phase = w_phase;
        n_tick  = w_tick;
        n_bit   = w_bit;
        n_acc   = w_acc;
        n_sec   = w_sec;
        w_store = 1'b0;
        w_drive = '{load_n: 1'b1, shift_clock: 1'b0, clock_enable: 1'b0,
                    busy_res: 1'b0, scan_done: 1'b0};
        case (w_phase)
            PH_LOAD: begin
                w_drive.load_n       = 1'b0;
                w_drive.clock_enable = 1'b1;
                w_drive.busy_res     = 1'b1;
                if (w_pulse_end) begin
                    n_tick  = '0;
                    n_phase = PH_SAMPLE;
                end else begin
                    n_tick = w_tick_inc[PULSE_TICKS_W-1:0];
                end
            end
            PH_SAMPLE: begin
                w_drive.busy_res = 1'b1;
                if (i_serial_in) begin
                    n_acc[w_bit] = 1'b1;
                end
                n_tick  = '0;
                n_phase = PH_CLKHI;
            end
            PH_CLKHI: begin
                w_drive.shift_clock = 1'b1;
                w_drive.busy_res    = 1'b1;
                if (w_pulse_end) begin
                    n_tick = '0;
                    if (w_bit == POS_W'(SECTION_BITS-1)) begin
                        // section complete: hand the word to the cache
                        w_store = 1'b1;
                        n_acc   = '0;
                        n_bit   = '0;
                        if (w_sec == '0) begin
                            w_drive.scan_done = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_sec   = w_sec - SEC_W'(1);
                            n_phase = PH_SAMPLE;
                        end
                    end else begin
                        n_bit   = w_bit + POS_W'(1);
                        n_phase = PH_SAMPLE;
                    end
                end else begin
                    n_tick = w_tick_inc[PULSE_TICKS_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // state advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_sec   <= '0;
            r_acc   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_sec   <= n_sec;
            r_acc   <= n_acc;
        end
    end

    assign o_drive      = w_drive;
    assign o_store_en   = w_store & i_step;
    assign o_store_sec  = w_sec;
    assign o_store_data = w_acc;

endmodule

FILE: hdl/srcr_cache.sv
// ----------------------------------------------------------------------------
// srcr_cache
// Pin cache: one word per section, written by the sequencer; decodes a
// one-based pin number into section and bit and returns the cached level.
// ----------------------------------------------------------------------------
module srcr_cache #(
    parameter int MAX_SECTIONS = 8,
    parameter int SECTION_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_store_en,
    input  logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] i_store_sec,
    input  logic [SECTION_BITS-1:0]             i_store_data,
    input  logic                                i_read_req,
    input  logic [srcr_pkg::PIN_W-1:0]          i_pin,
    input  logic [$clog2(MAX_SECTIONS+1)-1:0]   i_sections,
    output logic                                o_read_valid,
    output logic                                o_read_bit
);
    import srcr_pkg::*;

    localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int POS_W  = $clog2(SECTION_BITS);
    localparam int SCNT_W = $clog2(MAX_SECTIONS+1);
    localparam int LIM_W  = SCNT_W + $clog2(SECTION_BITS) + 1;
    localparam int CMP_W  = (LIM_W > PIN_W) ? LIM_W : PIN_W;

    logic [SECTION_BITS-1:0] r_cache [MAX_SECTIONS];
    logic [CMP_W-1:0]        w_idx;
    logic [CMP_W-1:0]        w_limit;
    logic [SEC_W-1:0]        w_sec;
    logic [POS_W-1:0]        w_pos;

    // section words, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_SECTIONS; k++) begin
                r_cache[k] <= '0;
            end
        end else if (i_store_en) begin
            r_cache[i_store_sec] <= i_store_data;
        end
    end

    // pin index and range limit
    assign w_idx   = CMP_W'(i_pin) - CMP_W'(1);
    assign w_limit = CMP_W'(i_sections) * CMP_W'(SECTION_BITS);

    // section split by independent boundary compares
    always_comb begin
        w_sec = '0;
        w_pos = w_idx[POS_W-1:0];
        for (int k = 1; k < MAX_SECTIONS; k++) begin
            if (w_idx >= CMP_W'(k * SECTION_BITS)) begin
                w_sec = SEC_W'(k);
                w_pos = POS_W'(w_idx - CMP_W'(k * SECTION_BITS));
            end
        end
    end

    // read sees the cache as it stood at the start of the tick
    always_comb begin
        o_read_valid = 1'b0;
        o_read_bit   = 1'b0;
        if (i_read_req && i_pin != '0 && w_idx < w_limit) begin
            o_read_valid = 1'b1;
            o_read_bit   = r_cache[w_sec][w_pos];
        end
    end

endmodule
